@@ sv/mfp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mfp_pkg;

  // Frame header layout
  localparam int unsigned HDR_BYTES = 15;
  localparam int unsigned CNT_W     = 17;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Header byte positions within the frame
  localparam logic [3:0] POS_VERSION    = 4'd0;
  localparam logic [3:0] POS_TYPE       = 4'd1;
  localparam logic [3:0] POS_FLAGS      = 4'd2;
  localparam logic [3:0] POS_CORR_FIRST = 4'd3;
  localparam logic [3:0] POS_CORR_LAST  = 4'd10;
  localparam logic [3:0] POS_SLEN       = 4'd11;
  localparam logic [3:0] POS_DLEN       = 4'd12;

  // Result kind codes
  localparam logic KIND_BODY    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Register map
  localparam int unsigned ADDR_W = 3;
  localparam logic [ADDR_W-1:0] REG_EXPECTED_VERSION = 3'd0;
  localparam logic [7:0] EXPECTED_VERSION_RST = 8'd1;

  // Output word layout
  localparam int unsigned TDATA_W = 128;
  localparam int unsigned TUSER_W = 3;

  typedef enum logic [1:0] {
    SEG_SENDER = 2'd0,
    SEG_DEST   = 2'd1,
    SEG_PAYLOAD = 2'd2,
    SEG_EXCESS = 2'd3
  } seg_t;

  typedef enum logic [1:0] {
    ST_OK            = 2'd0,
    ST_SHORT         = 2'd1,
    ST_BAD_VERSION   = 2'd2,
    ST_SIZE_MISMATCH = 2'd3
  } status_t;

  // Command from front to back
  typedef struct packed {
    logic        has_body;
    seg_t        seg;
    logic [7:0]  data;
    logic        has_sum;
    status_t     status;
    logic [7:0]  ftype;
    logic [7:0]  flags;
    logic [63:0] corr;
    logic [7:0]  slen;
    logic [7:0]  dlen;
    logic [15:0] plen;
  } mfp_cmd_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic     valid;
    mfp_cmd_t cmd;
  } mfp_head_t;

endpackage

`default_nettype wire

@@ sv/message_frame_parser_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Byte-serial message frame parser. One byte is taken per cycle on the s_
// side while the queue is not full; s_tlast marks the last byte of a
// frame. The 15 header bytes give no output unless the frame ends there;
// each later byte gives one body word tagged sender, destination, payload
// or excess, and the last byte of a frame adds a summary word with the
// header fields and status. The output register moves one word per clock
// unless stalled, so a body byte ending a frame gives two output words; a
// queue of QUEUE_DEPTH commands between front and back end absorbs that
// and downstream stalls. expected_version is written over APB at address
// 0 and resets to 1; there is no clearing pass after reset.

module message_frame_parser_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // s_tdata: [7:0] in_byte; s_tlast: end_of_frame
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [7:0]                  s_tdata,
  input  wire logic                        s_tlast,
  // m_tdata: [7:0] body_byte, [15:8] frame_type, [23:16] frame_flags,
  //   [87:24] frame_correlation, [95:88] frame_sender_len,
  //   [103:96] frame_dest_len, [119:104] frame_payload_len,
  //   [121:120] status, [127:122] zero
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [mfp_pkg::TDATA_W-1:0]      m_tdata,
  // m_tuser: [0] kind, [2:1] segment; m_tlast: last_of_run
  output logic [mfp_pkg::TUSER_W-1:0]      m_tuser,
  output logic                             m_tlast,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [mfp_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  logic               expected_version;
  logic [7:0]         exp_ver;
  logic               accept, push, pop, full;
  mfp_pkg::mfp_cmd_t  cmd;
  mfp_pkg::mfp_head_t head;

  assign pready   = 1'b1;
  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;
  assign expected_version = (paddr == mfp_pkg::REG_EXPECTED_VERSION);

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      exp_ver <= mfp_pkg::EXPECTED_VERSION_RST;
    end else if (psel && penable && pwrite && pready && expected_version) begin
      exp_ver <= pwdata[7:0];
    end
  end

  // Register read
  assign prdata = expected_version ? {24'b0, exp_ver} : 32'b0;

  mfp_front u_front (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .in_byte          (s_tdata),
    .end_of_frame     (s_tlast),
    .expected_version (exp_ver),
    .cmd              (cmd),
    .push             (push)
  );

  mfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (cmd),
    .pop      (pop),
    .head     (head),
    .full     (full)
  );

  mfp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

@@ sv/mfp_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mfp_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire logic [7:0]        in_byte,
  input  wire logic              end_of_frame,
  input  wire logic [7:0]        expected_version,
  output mfp_pkg::mfp_cmd_t      cmd,
  output logic                   push
);

  logic [mfp_pkg::CNT_W-1:0] cnt, cnt_next, cnt_inc;
  logic                      ver_bad, ver_bad_next;
  logic [7:0]                h_type, h_type_next;
  logic [7:0]                h_flags, h_flags_next;
  logic [63:0]               h_corr, h_corr_next;
  logic [7:0]                h_slen, h_slen_next;
  logic [7:0]                h_dlen, h_dlen_next;
  logic [15:0]               h_plen, h_plen_next;
  logic [mfp_pkg::CNT_W-1:0] bnd_s, bnd_s_next;
  logic [mfp_pkg::CNT_W-1:0] bnd_d, bnd_d_next;
  logic [mfp_pkg::CNT_W-1:0] bnd_p, bnd_p_next;
  logic                      in_hdr;
  mfp_pkg::seg_t             seg;
  mfp_pkg::status_t          status;

  assign in_hdr  = cnt < mfp_pkg::CNT_W'(mfp_pkg::HDR_BYTES);
  assign cnt_inc = (cnt == mfp_pkg::CNT_MAX) ? cnt : cnt + 1'b1;

  // Capture header fields and segment bounds
  always_comb begin
    ver_bad_next = ver_bad;
    h_type_next  = h_type;
    h_flags_next = h_flags;
    h_corr_next  = h_corr;
    h_slen_next  = h_slen;
    h_dlen_next  = h_dlen;
    h_plen_next  = h_plen;
    bnd_s_next   = bnd_s;
    bnd_d_next   = bnd_d;
    bnd_p_next   = bnd_p;
    if (in_hdr) begin
      unique case (cnt[3:0]) inside
        mfp_pkg::POS_VERSION: ver_bad_next = (in_byte != expected_version);
        mfp_pkg::POS_TYPE:    h_type_next  = in_byte;
        mfp_pkg::POS_FLAGS:   h_flags_next = in_byte;
        [mfp_pkg::POS_CORR_FIRST:mfp_pkg::POS_CORR_LAST]:
          h_corr_next = {h_corr[55:0], in_byte};
        mfp_pkg::POS_SLEN: begin
          h_slen_next = in_byte;
          bnd_s_next  = mfp_pkg::CNT_W'(mfp_pkg::HDR_BYTES) + mfp_pkg::CNT_W'(in_byte);
        end
        mfp_pkg::POS_DLEN: begin
          h_dlen_next = in_byte;
          bnd_d_next  = bnd_s + mfp_pkg::CNT_W'(in_byte);
        end
        default: begin
          h_plen_next = {h_plen[7:0], in_byte};
          bnd_p_next  = bnd_d + mfp_pkg::CNT_W'({h_plen[7:0], in_byte});
        end
      endcase
    end
  end

  // Classify body byte against the precomputed bounds
  always_comb begin
    if (cnt < bnd_s) begin
      seg = mfp_pkg::SEG_SENDER;
    end else if (cnt < bnd_d) begin
      seg = mfp_pkg::SEG_DEST;
    end else if (cnt < bnd_p) begin
      seg = mfp_pkg::SEG_PAYLOAD;
    end else begin
      seg = mfp_pkg::SEG_EXCESS;
    end
  end

  // Frame status in priority order
  always_comb begin
    if (cnt_inc < mfp_pkg::CNT_W'(mfp_pkg::HDR_BYTES)) begin
      status = mfp_pkg::ST_SHORT;
    end else if (ver_bad_next) begin
      status = mfp_pkg::ST_BAD_VERSION;
    end else if (cnt_inc != bnd_p_next) begin
      status = mfp_pkg::ST_SIZE_MISMATCH;
    end else begin
      status = mfp_pkg::ST_OK;
    end
  end

  // Build the word for the back end
  always_comb begin
    cmd.has_body = !in_hdr;
    cmd.seg      = seg;
    cmd.data     = in_byte;
    cmd.has_sum  = end_of_frame;
    cmd.status   = status;
    cmd.ftype    = h_type_next;
    cmd.flags    = h_flags_next;
    cmd.corr     = h_corr_next;
    cmd.slen     = h_slen_next;
    cmd.dlen     = h_dlen_next;
    cmd.plen     = h_plen_next;
  end

  assign push     = accept && (!in_hdr || end_of_frame);
  assign cnt_next = cnt_inc;

  // Advance frame state; clear at end of frame
  always_ff @(posedge clk) begin
    if (rst || (accept && end_of_frame)) begin
      cnt     <= '0;
      ver_bad <= 1'b0;
      h_type  <= '0;
      h_flags <= '0;
      h_corr  <= '0;
      h_slen  <= '0;
      h_dlen  <= '0;
      h_plen  <= '0;
      bnd_s   <= '0;
      bnd_d   <= '0;
      bnd_p   <= '0;
    end else if (accept) begin
      cnt     <= cnt_next;
      ver_bad <= ver_bad_next;
      h_type  <= h_type_next;
      h_flags <= h_flags_next;
      h_corr  <= h_corr_next;
      h_slen  <= h_slen_next;
      h_dlen  <= h_dlen_next;
      h_plen  <= h_plen_next;
      bnd_s   <= bnd_s_next;
      bnd_d   <= bnd_d_next;
      bnd_p   <= bnd_p_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/mfp_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mfp_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire mfp_pkg::mfp_cmd_t  push_cmd,
  input  wire logic               pop,
  output mfp_pkg::mfp_head_t      head,
  output logic                    full
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

  mfp_pkg::mfp_cmd_t slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  fill;

  assign full       = (fill == CNT_W'(DEPTH));
  assign head.valid = (fill != '0);
  assign head.cmd   = slots[rd_ptr];

  // Store incoming word
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue push while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> head.valid)
    else $error("queue pop while empty");
  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (fill == $past(fill) + 1'b1))
    else $error("queue fill did not advance on push");

endmodule

`default_nettype wire

@@ sv/mfp_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mfp_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire mfp_pkg::mfp_head_t            head,
  output logic                               pop,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [mfp_pkg::TDATA_W-1:0]        m_tdata,
  output logic [mfp_pkg::TUSER_W-1:0]        m_tuser,
  output logic                               m_tlast
);

  logic                        phase, phase_next;
  logic                        out_free, load, send_sum, final_word;
  logic [mfp_pkg::TDATA_W-1:0] data_next;
  logic [mfp_pkg::TUSER_W-1:0] user_next;
  logic                        last_next;
  mfp_pkg::mfp_cmd_t           c;

  assign c          = head.cmd;
  assign out_free   = !m_tvalid || m_tready;
  assign load       = out_free && head.valid;
  assign send_sum   = phase || !c.has_body;
  assign final_word = send_sum || !c.has_sum;
  assign pop        = load && final_word;
  assign phase_next = load ? !final_word : phase;

  // Build the next output word: body byte first, then the summary
  always_comb begin
    if (send_sum) begin
      data_next = {6'b0, c.status, c.plen, c.dlen, c.slen, c.corr, c.flags, c.ftype, 8'b0};
      user_next = {mfp_pkg::SEG_SENDER, mfp_pkg::KIND_SUMMARY};
      last_next = 1'b1;
    end else begin
      data_next = {{(mfp_pkg::TDATA_W - 8){1'b0}}, c.data};
      user_next = {c.seg, mfp_pkg::KIND_BODY};
      last_next = !c.has_sum;
    end
  end

  // Hold phase between the two results of one byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      phase <= phase_next;
      if (out_free) begin
        m_tvalid <= head.valid;
      end
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= data_next;
      m_tuser <= user_next;
      m_tlast <= last_next;
    end
  end

  a_sum_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0] == mfp_pkg::KIND_SUMMARY) |-> m_tlast)
    else $error("summary word without last mark");
  a_body_clean: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0] == mfp_pkg::KIND_BODY) |-> (m_tdata[127:8] == '0))
    else $error("body word carries header fields");
  a_phase_pair: assert property (@(posedge clk) disable iff (rst)
    phase |-> (head.valid && head.cmd.has_body && head.cmd.has_sum))
    else $error("summary phase without a pending body-and-summary word");

endmodule

`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned PHASE_ITEMS  = 420;
  localparam int unsigned HOLD_CYCLES  = 300;

  // One output word as the parser should produce it
  typedef struct packed {
    logic              kind;
    mfp_pkg::seg_t     seg;
    logic [7:0]        data;
    logic [7:0]        ftype;
    logic [7:0]        flags;
    logic [63:0]       corr;
    logic [7:0]        slen;
    logic [7:0]        dlen;
    logic [15:0]       plen;
    mfp_pkg::status_t  status;
    logic              last;
  } frame_word_t;

  // Frame state tracker and queue of words still owed by the parser
  class frame_scoreboard;
    logic [7:0]                want_version = mfp_pkg::EXPECTED_VERSION_RST;
    logic [mfp_pkg::CNT_W-1:0] count = '0;
    logic                      version_bad = 1'b0;
    logic [7:0]                held_type = '0;
    logic [7:0]                held_flags = '0;
    logic [63:0]               held_corr = '0;
    logic [7:0]                held_slen = '0;
    logic [7:0]                held_dlen = '0;
    logic [15:0]               held_plen = '0;
    frame_word_t               pending_words[$];
    int                        errors = 0;

    // Append one owed word at the tail
    function void queue_word(frame_word_t w);
      pending_words = {pending_words, w};
    endfunction

    // Advance the frame state by one accepted byte and queue its words
    function void note_byte(logic [7:0] b, logic eof);
      frame_word_t w;
      mfp_pkg::seg_t sg;
      int unsigned off, s, d, p, total, want;
      if (count < mfp_pkg::HDR_BYTES) begin
        if (count == mfp_pkg::POS_VERSION) version_bad = (b != want_version);
        else if (count == mfp_pkg::POS_TYPE) held_type = b;
        else if (count == mfp_pkg::POS_FLAGS) held_flags = b;
        else if (count <= mfp_pkg::POS_CORR_LAST) held_corr = {held_corr[55:0], b};
        else if (count == mfp_pkg::POS_SLEN) held_slen = b;
        else if (count == mfp_pkg::POS_DLEN) held_dlen = b;
        else held_plen = {held_plen[7:0], b};
      end else begin
        off = count;
        off -= mfp_pkg::HDR_BYTES;
        s = held_slen;
        d = s + held_dlen;
        p = d + held_plen;
        if (off < s) sg = mfp_pkg::SEG_SENDER;
        else if (off < d) sg = mfp_pkg::SEG_DEST;
        else if (off < p) sg = mfp_pkg::SEG_PAYLOAD;
        else sg = mfp_pkg::SEG_EXCESS;
        w = '0;
        w.kind = mfp_pkg::KIND_BODY;
        w.seg = sg;
        w.data = b;
        w.status = mfp_pkg::ST_OK;
        w.last = !eof;
        queue_word(w);
      end
      // Saturate the byte counter
      if (count != mfp_pkg::CNT_MAX) count++;
      if (eof) begin
        total = count;
        want = mfp_pkg::HDR_BYTES + held_slen + held_dlen + held_plen;
        w = '0;
        w.kind = mfp_pkg::KIND_SUMMARY;
        w.seg = mfp_pkg::SEG_SENDER;
        w.ftype = held_type;
        w.flags = held_flags;
        w.corr = held_corr;
        w.slen = held_slen;
        w.dlen = held_dlen;
        w.plen = held_plen;
        if (total < mfp_pkg::HDR_BYTES) w.status = mfp_pkg::ST_SHORT;
        else if (version_bad) w.status = mfp_pkg::ST_BAD_VERSION;
        else if (total != want) w.status = mfp_pkg::ST_SIZE_MISMATCH;
        else w.status = mfp_pkg::ST_OK;
        w.last = 1'b1;
        queue_word(w);
        // Drop all frame state for the next frame
        count = '0;
        version_bad = 1'b0;
        held_type = '0;
        held_flags = '0;
        held_corr = '0;
        held_slen = '0;
        held_dlen = '0;
        held_plen = '0;
      end
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    // Check one accepted output word against the oldest expectation
    function void check_word(logic [mfp_pkg::TDATA_W-1:0] tdata,
                             logic [mfp_pkg::TUSER_W-1:0] tuser, logic tlast);
      frame_word_t w;
      if (pending_words.size() == 0) begin
        $error("unexpected word: tdata 0x%0h tuser 0x%0h tlast %0b", tdata, tuser, tlast);
        errors++;
        return;
      end
      w = pending_words.pop_front();
      compare_field("kind", w.kind, tuser[0]);
      compare_field("segment", w.seg, tuser[2:1]);
      compare_field("body_byte", w.data, tdata[7:0]);
      compare_field("frame_type", w.ftype, tdata[15:8]);
      compare_field("frame_flags", w.flags, tdata[23:16]);
      compare_field("frame_correlation", w.corr, tdata[87:24]);
      compare_field("frame_sender_len", w.slen, tdata[95:88]);
      compare_field("frame_dest_len", w.dlen, tdata[103:96]);
      compare_field("frame_payload_len", w.plen, tdata[119:104]);
      compare_field("status", w.status, tdata[121:120]);
      compare_field("last_of_run", w.last, tlast);
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic [7:0]                   s_tdata = '0;
  logic                         s_tlast = 1'b0;
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [mfp_pkg::TDATA_W-1:0]  m_tdata;
  logic [mfp_pkg::TUSER_W-1:0]  m_tuser;
  logic                         m_tlast;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [mfp_pkg::ADDR_W-1:0]   paddr = '0;
  logic [31:0]                  pwdata = '0;
  logic [31:0]                  prdata;
  logic                         pready;

  frame_scoreboard sb = new();
  bit                   tx_gaps = 1'b1;
  bit                   rx_gaps = 1'b1;
  int unsigned          rx_hold = 0;
  int unsigned          items_sent = 0;
  int unsigned          stall_cycles = 0;

  message_frame_parser_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Check output words and watch for a hung handshake
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_word(m_tdata, m_tuser, m_tlast);
    if (rst || (m_tvalid && m_tready) || (s_tvalid && s_tready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver: random wait per word, plus a long hold-off on request
  initial begin : receiver
    int unsigned w;
    while (rst) @(posedge clk);
    forever begin
      if (rx_hold > 0) begin
        m_tready <= 1'b0;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
      end
      w = rx_gaps ? $urandom_range(0, 11) : 0;
      if (w > 0) begin
        m_tready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // Offer one byte after a random gap and hold it until taken
  task automatic send_byte(input logic [7:0] b, input logic eof);
    int unsigned gap;
    gap = tx_gaps ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= eof;
    do @(posedge clk); while (!s_tready);
    sb.note_byte(b, eof);
    items_sent++;
  endtask

  // Send a frame of total bytes: header from the fields, random body
  task automatic send_frame(input logic [7:0] ver, input logic [7:0] typ,
                            input logic [7:0] flg, input logic [63:0] corr,
                            input logic [7:0] sl, input logic [7:0] dl,
                            input logic [15:0] pl, input int unsigned total);
    logic [7:0] hdr [mfp_pkg::HDR_BYTES];
    hdr[mfp_pkg::POS_VERSION] = ver;
    hdr[mfp_pkg::POS_TYPE] = typ;
    hdr[mfp_pkg::POS_FLAGS] = flg;
    for (int i = 0; i < 8; i++) hdr[mfp_pkg::POS_CORR_FIRST + i] = corr[63 - 8*i -: 8];
    hdr[mfp_pkg::POS_SLEN] = sl;
    hdr[mfp_pkg::POS_DLEN] = dl;
    hdr[mfp_pkg::HDR_BYTES-2] = pl[15:8];
    hdr[mfp_pkg::HDR_BYTES-1] = pl[7:0];
    for (int unsigned i = 0; i < total; i++)
      send_byte((i < mfp_pkg::HDR_BYTES) ? hdr[i] : 8'($urandom), i == total - 1);
  endtask

  task automatic apb_access(input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= mfp_pkg::REG_EXPECTED_VERSION;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    // Return to idle between transfers
    @(posedge clk);
  endtask

  task automatic check_version_reg();
    logic [31:0] rd;
    apb_access(1'b0, '0, rd);
    if (rd !== {24'h0, sb.want_version}) begin
      $error("expected_version readback mismatch: expected 0x%0h, got 0x%0h",
             sb.want_version, rd);
      sb.errors++;
    end
  endtask

  task automatic set_version(input logic [7:0] v);
    logic [31:0] rd;
    apb_access(1'b1, {24'h0, v}, rd);
    sb.want_version = v;
    check_version_reg();
  endtask

  // Stop offering bytes and wait until every owed word is out
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sb.pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly well-formed frames, the rest broken or pure noise
  task automatic random_frame();
    logic [7:0] ver, typ, flg, sl, dl;
    logic [63:0] corr;
    logic [15:0] pl;
    int unsigned pick, exact, total;
    pick = $urandom_range(0, 99);
    tx_gaps = ($urandom_range(0, 3) != 0);
    rx_gaps = ($urandom_range(0, 3) != 0);
    ver = sb.want_version;
    typ = 8'($urandom);
    flg = 8'($urandom);
    corr = {$urandom, $urandom};
    sl = 8'($urandom_range(0, 4));
    dl = 8'($urandom_range(0, 4));
    pl = 16'($urandom_range(0, 6));
    exact = mfp_pkg::HDR_BYTES + sl + dl + pl;
    total = exact;
    if (pick < 12) begin
      ver = sb.want_version ^ 8'($urandom_range(1, 255));
    end else if (pick < 24) begin
      if ($urandom_range(0, 1) && exact > mfp_pkg::HDR_BYTES)
        total = $urandom_range(mfp_pkg::HDR_BYTES, exact - 1);
      else total = exact + $urandom_range(1, 6);
    end else if (pick < 34) begin
      total = $urandom_range(1, mfp_pkg::HDR_BYTES - 1);
    end else if (pick < 44) begin
      ver = 8'($urandom);
      sl = 8'($urandom);
      dl = 8'($urandom);
      pl = 16'($urandom);
      total = $urandom_range(1, 40);
    end
    send_frame(ver, typ, flg, corr, sl, dl, pl, total);
  endtask

  initial begin : stimulus
    logic [7:0] versions [4];
    int unsigned goal;
    versions[0] = mfp_pkg::EXPECTED_VERSION_RST;
    versions[1] = 8'h00;
    versions[2] = 8'hFF;
    versions[3] = 8'($urandom_range(2, 254));
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    check_version_reg();

    // Lone version byte, cut-off correlation id, header-only frame
    send_frame(8'hFF, 8'h00, 8'h00, 64'h0, 8'h00, 8'h00, 16'h0, 1);
    send_frame(mfp_pkg::EXPECTED_VERSION_RST, 8'h5A, 8'hA5, 64'h0123_4567_89AB_CDEF,
               8'h00, 8'h00, 16'h0, 9);
    send_frame(mfp_pkg::EXPECTED_VERSION_RST, 8'hFF, 8'hFF, '1, 8'h00, 8'h00, 16'h0,
               mfp_pkg::HDR_BYTES);

    goal = items_sent;
    for (int ph = 0; ph < 4; ph++) begin
      if (ph > 0) begin
        wait_drained();
        set_version(versions[ph]);
      end
      goal += PHASE_ITEMS;
      if (ph == 1) begin
        // Hold the output off while bytes keep coming, to back up the input
        tx_gaps = 1'b0;
        rx_hold = HOLD_CYCLES;
        send_frame(sb.want_version, 8'($urandom), 8'($urandom), {$urandom, $urandom},
                   8'd40, 8'd40, 16'd40, mfp_pkg::HDR_BYTES + 120);
      end
      while (items_sent < goal) random_frame();
    end

    wait_drained();
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/mfp_pkg.sv
sv/mfp_front.sv
sv/mfp_queue.sv
sv/mfp_back.sv
sv/message_frame_parser_core.sv
bench/tb.sv
